FILE: hw/rtl/adv_uuid16_search_assert.svh
// Assertion macros for the advertising UUID search block.
// AUS_ASSERT checks a property on the rising edge of aclk outside reset.
// AUS_ASSERT_ALWAYS checks a property on every rising edge of aclk.
`ifndef ADV_UUID16_SEARCH_ASSERT_SVH
`define ADV_UUID16_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define AUS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("adv_uuid16_search assertion failed");
`define AUS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("adv_uuid16_search assertion failed");
`else
`define AUS_ASSERT(lbl, prop)
`define AUS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: hw/rtl/advu16_pkg.sv
package advu16_pkg;

    typedef enum logic [2:0] {
        PH_LEN  = 3'd0,
        PH_TYPE = 3'd1,
        PH_LO   = 3'd2,
        PH_HI   = 3'd3,
        PH_SKIP = 3'd4
    } phase_t;

    localparam logic [7:0] AD_UUID16_MORE     = 8'h02;
    localparam logic [7:0] AD_UUID16_COMPLETE = 8'h03;
    localparam logic [7:0] UUID_BYTES         = 8'd2;

    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0] REG_TARGET_UUID = 1'b0;

    function automatic phase_t list_phase(input logic [7:0] rem);
        phase_t ph;
        if (rem >= UUID_BYTES) begin
            ph = PH_LO;
        end else if (rem == 8'd1) begin
            ph = PH_SKIP;
        end else begin
            ph = PH_LEN;
        end
        return ph;
    endfunction

endpackage

FILE: hw/rtl/adv_uuid16_search.sv
// Searches a BLE advertising payload, given one byte per item with last on
// the final byte, for the 16-bit service UUID held in target_uuid (address 0).
// Each byte is parsed combinationally, so an item is accepted every cycle
// while the result register is free or being emptied; one found item is
// given for each payload, in the cycle after its last byte is accepted.
`include "adv_uuid16_search_assert.svh"

module adv_uuid16_search (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [advu16_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found
);

    logic [15:0]        target_uuid_reg;
    advu16_pkg::phase_t phase_reg, phase_next;
    logic [7:0]         remaining_reg, remaining_next;
    logic [7:0]         held_low_byte_reg, held_low_byte_next;
    logic               match_seen_reg, match_seen_next;
    logic               match_step;
    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic               in_acc;
    logic               cfg_wr;
    logic [7:0]         rem_dec;
    logic [7:0]         rem_pair;
    logic               is_list;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == advu16_pkg::REG_TARGET_UUID) ?
                     {16'd0, target_uuid_reg} : 32'd0;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_acc  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;

    assign rem_dec  = remaining_reg - 8'd1;
    assign rem_pair = remaining_reg - advu16_pkg::UUID_BYTES;
    assign is_list  = (s_data_byte == advu16_pkg::AD_UUID16_MORE) ||
                      (s_data_byte == advu16_pkg::AD_UUID16_COMPLETE);

    always_comb begin
        phase_next         = phase_reg;
        remaining_next     = remaining_reg;
        held_low_byte_next = held_low_byte_reg;
        match_step         = match_seen_reg;
        case (phase_reg)
            advu16_pkg::PH_TYPE: begin
                remaining_next = rem_dec;
                if (is_list) begin
                    phase_next = advu16_pkg::list_phase(rem_dec);
                end else begin
                    phase_next = (rem_dec != 8'd0) ? advu16_pkg::PH_SKIP
                                                   : advu16_pkg::PH_LEN;
                end
            end
            advu16_pkg::PH_LO: begin
                held_low_byte_next = s_data_byte;
                phase_next         = advu16_pkg::PH_HI;
            end
            advu16_pkg::PH_HI: begin
                if (held_low_byte_reg == target_uuid_reg[7:0] &&
                    s_data_byte == target_uuid_reg[15:8]) begin
                    match_step = 1'b1;
                end
                remaining_next = rem_pair;
                phase_next     = advu16_pkg::list_phase(rem_pair);
            end
            advu16_pkg::PH_SKIP: begin
                remaining_next = rem_dec;
                if (rem_dec == 8'd0) begin
                    phase_next = advu16_pkg::PH_LEN;
                end
            end
            default: begin
                if (s_data_byte != 8'd0) begin
                    remaining_next = s_data_byte;
                    phase_next     = advu16_pkg::PH_TYPE;
                end else begin
                    phase_next = advu16_pkg::PH_LEN;
                end
            end
        endcase
        match_seen_next = match_step;
        if (s_last) begin
            phase_next         = advu16_pkg::PH_LEN;
            remaining_next     = 8'd0;
            held_low_byte_next = 8'd0;
            match_seen_next    = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (in_acc && s_last) begin
            m_valid_next = 1'b1;
            m_found_next = match_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_uuid_reg   <= 16'd0;
            phase_reg         <= advu16_pkg::PH_LEN;
            remaining_reg     <= 8'd0;
            held_low_byte_reg <= 8'd0;
            match_seen_reg    <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == advu16_pkg::REG_TARGET_UUID) begin
                target_uuid_reg <= pwdata[15:0];
            end
            if (in_acc) begin
                phase_reg         <= phase_next;
                remaining_reg     <= remaining_next;
                held_low_byte_reg <= held_low_byte_next;
                match_seen_reg    <= match_seen_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_found_reg <= m_found_next;
    end

    `AUS_ASSERT(a_result_after_last, $rose(m_valid_reg) |-> $past(in_acc && s_last))
    `AUS_ASSERT(a_clear_after_last, (in_acc && s_last) |=>
        (phase_reg == advu16_pkg::PH_LEN && remaining_reg == 8'd0 && !match_seen_reg))
    `AUS_ASSERT(a_skip_has_bytes, (phase_reg == advu16_pkg::PH_SKIP) |-> (remaining_reg != 8'd0))
    `AUS_ASSERT(a_stall_blocks_input, (m_valid_reg && !m_ready) |-> !s_ready)
    `AUS_ASSERT(a_parse_holds_idle, !$past(in_acc) |-> $stable(phase_reg))

endmodule
